[hdl/cawk_pkg.sv]
// Package with the types, constants and helpers shared by the alignment walker files.
`default_nettype none

package cawk_pkg;

  localparam int POSITION_BITS = 32;
  localparam int LENGTH_BITS   = 28;

  localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

  // Item functions on the input channel.
  typedef enum logic [1:0] {
    FUNC_START = 2'd0,
    FUNC_CIGAR = 2'd1,
    FUNC_CS    = 2'd2,
    FUNC_END   = 2'd3
  } cawk_func_e;

  // Kind of the cs token that is being collected.
  typedef enum logic [2:0] {
    TK_NONE  = 3'd0,
    TK_MATCH = 3'd1,
    TK_MISM  = 3'd2,
    TK_INS   = 3'd3,
    TK_DEL   = 3'd4
  } cawk_tok_e;

  // BAM operation codes.
  localparam logic [3:0] OP_M   = 4'd0;
  localparam logic [3:0] OP_I   = 4'd1;
  localparam logic [3:0] OP_D   = 4'd2;
  localparam logic [3:0] OP_N   = 4'd3;
  localparam logic [3:0] OP_S   = 4'd4;
  localparam logic [3:0] OP_H   = 4'd5;
  localparam logic [3:0] OP_P   = 4'd6;
  localparam logic [3:0] OP_EQ  = 4'd7;
  localparam logic [3:0] OP_X   = 4'd8;

  // cs tag characters.
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LOW_A = 8'h61;
  localparam logic [7:0] CH_LOW_Z = 8'h7A;

  typedef struct packed {
    cawk_func_e  func;
    logic [30:0] start_position;
    logic        is_reverse;
    logic [29:0] total_read_length;
    logic [3:0]  cigar_op;
    logic [27:0] cigar_length;
    logic [7:0]  cs_byte;
  } cawk_in_t;

  typedef struct packed {
    logic [3:0]         op_code;
    logic [27:0]        op_length;
    logic signed [31:0] read_start;
    logic signed [31:0] read_end;
    logic [30:0]        seq_start;
    logic signed [31:0] seq_end;
    logic [30:0]        ref_start;
    logic signed [31:0] ref_end;
  } cawk_out_t;

  // One operation to be applied to the running intervals.
  typedef struct packed {
    logic                   valid;
    logic [3:0]             op;
    logic [LENGTH_BITS-1:0] len;
    logic                   rd;
    logic                   sq;
    logic                   rf;
  } cawk_req_t;

  // Sign-extends a position from its register width to 64 bits.
  function automatic logic [63:0] pos_sext(logic [POSITION_BITS-1:0] v);
    logic signed [POSITION_BITS-1:0] s;
    s = v;
    return 64'(s);
  endfunction

endpackage

`default_nettype wire

[hdl/cawk_if.sv]
// Valid/ready stream interfaces for the input items and the result items.
`default_nettype none

interface cawk_in_if;
  logic               valid;
  logic               ready;
  cawk_pkg::cawk_in_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface cawk_out_if;
  logic                valid;
  logic                ready;
  cawk_pkg::cawk_out_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[hdl/cawk_decode.sv]
// Decoder that turns CIGAR words and cs-tag bytes into operation requests.
`default_nettype none

module cawk_decode (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                en_i,
  input  wire cawk_pkg::cawk_in_t  item_i,
  output cawk_pkg::cawk_req_t      req_o
);
  import cawk_pkg::*;

  localparam int PW = LENGTH_BITS + 4;

  cawk_tok_e              kind_q, kind_d;
  logic [LENGTH_BITS-1:0] len_q, len_d;
  cawk_req_t              flush_req;
  logic                   is_digit, is_letter;
  logic [PW-1:0]          dec_prod;

  assign is_digit  = (item_i.cs_byte >= CH_ZERO) && (item_i.cs_byte <= CH_NINE);
  assign is_letter = (item_i.cs_byte >= CH_LOW_A) && (item_i.cs_byte <= CH_LOW_Z);

  // For a decimal digit the low nibble of the character is its value.
  assign dec_prod = (PW'(len_q) << 3) + (PW'(len_q) << 1) + PW'(item_i.cs_byte[3:0]);

  always_comb begin
    flush_req       = '0;
    flush_req.valid = (kind_q != TK_NONE) && (len_q != '0);
    flush_req.len   = len_q;
    case (kind_q)
      TK_MATCH: begin
        flush_req.op = OP_EQ;
        flush_req.rd = 1'b1;
        flush_req.sq = 1'b1;
        flush_req.rf = 1'b1;
      end
      TK_MISM: begin
        flush_req.op  = OP_X;
        flush_req.len = LENGTH_BITS'(1);
        flush_req.rd  = 1'b1;
        flush_req.sq  = 1'b1;
        flush_req.rf  = 1'b1;
      end
      TK_INS: begin
        flush_req.op = OP_I;
        flush_req.rd = 1'b1;
        flush_req.sq = 1'b1;
      end
      default: begin
        flush_req.op = OP_D;
        flush_req.rf = 1'b1;
      end
    endcase
  end

  always_comb begin
    kind_d = kind_q;
    len_d  = len_q;
    req_o  = '0;
    case (item_i.func)
      FUNC_START: begin
        kind_d = TK_NONE;
        len_d  = '0;
      end
      FUNC_CIGAR: begin
        req_o.valid = 1'b1;
        req_o.op    = item_i.cigar_op;
        if (33'(item_i.cigar_length) > 33'(LEN_MAX)) begin
          req_o.len = LEN_MAX;
        end else begin
          req_o.len = LENGTH_BITS'(item_i.cigar_length);
        end
        case (item_i.cigar_op)
          OP_M, OP_EQ, OP_X: begin
            req_o.rd = 1'b1;
            req_o.sq = 1'b1;
            req_o.rf = 1'b1;
          end
          OP_I, OP_S: begin
            req_o.rd = 1'b1;
            req_o.sq = 1'b1;
          end
          OP_D, OP_N: req_o.rf = 1'b1;
          OP_H:       req_o.rd = 1'b1;
          default:    ;
        endcase
      end
      FUNC_END: begin
        req_o  = flush_req;
        kind_d = TK_NONE;
        len_d  = '0;
      end
      default: begin
        if ((kind_q == TK_MATCH) && is_digit) begin
          if (dec_prod > PW'(LEN_MAX)) begin
            len_d = LEN_MAX;
          end else begin
            len_d = LENGTH_BITS'(dec_prod);
          end
        end else if ((kind_q != TK_NONE) && (kind_q != TK_MATCH) && is_letter) begin
          if (len_q != LEN_MAX) begin
            len_d = len_q + LENGTH_BITS'(1);
          end
        end else begin
          req_o = flush_req;
          len_d = '0;
          case (item_i.cs_byte)
            CH_COLON: kind_d = TK_MATCH;
            CH_STAR:  kind_d = TK_MISM;
            CH_PLUS:  kind_d = TK_INS;
            CH_MINUS: kind_d = TK_DEL;
            default:  kind_d = TK_NONE;
          endcase
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q <= TK_NONE;
      len_q  <= '0;
    end else if (en_i) begin
      kind_q <= kind_d;
      len_q  <= len_d;
    end
  end

endmodule

`default_nettype wire

[hdl/cawk_track.sv]
// Running read, sequence and reference intervals and the result fields they give.
`default_nettype none

module cawk_track (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                en_i,
  input  wire cawk_pkg::cawk_in_t  item_i,
  input  wire cawk_pkg::cawk_req_t req_i,
  output cawk_pkg::cawk_out_t      result_o
);
  import cawk_pkg::*;

  localparam int PB = POSITION_BITS;

  logic          reverse_q;
  logic [PB-1:0] read_lo_q, read_lo_d;
  logic [PB-1:0] read_hi_q, read_hi_d;
  logic [PB-1:0] seq_hi_q, seq_hi_d;
  logic [PB-1:0] ref_hi_q, ref_hi_d;
  logic [PB-1:0] step, seq_lo, ref_lo, total;
  logic [63:0]   x_rs, x_re, x_ss, x_se, x_fs, x_fe;

  assign step  = PB'(req_i.len);
  assign total = PB'(item_i.total_read_length);

  always_comb begin
    if (reverse_q) begin
      read_hi_d = read_lo_q - PB'(1);
      read_lo_d = read_lo_q - (req_i.rd ? step : '0);
    end else begin
      read_lo_d = read_hi_q + PB'(1);
      read_hi_d = read_hi_q + (req_i.rd ? step : '0);
    end
    seq_lo   = seq_hi_q + PB'(1);
    seq_hi_d = seq_hi_q + (req_i.sq ? step : '0);
    ref_lo   = ref_hi_q + PB'(1);
    ref_hi_d = ref_hi_q + (req_i.rf ? step : '0);
  end

  assign x_rs = pos_sext(read_lo_d);
  assign x_re = pos_sext(read_hi_d);
  assign x_ss = pos_sext(seq_lo);
  assign x_se = pos_sext(seq_hi_d);
  assign x_fs = pos_sext(ref_lo);
  assign x_fe = pos_sext(ref_hi_d);

  always_comb begin
    result_o.op_code    = req_i.op;
    result_o.op_length  = 28'(req_i.len);
    result_o.read_start = x_rs[31:0];
    result_o.read_end   = x_re[31:0];
    result_o.seq_start  = x_ss[30:0];
    result_o.seq_end    = x_se[31:0];
    result_o.ref_start  = x_fs[30:0];
    result_o.ref_end    = x_fe[31:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reverse_q <= 1'b0;
      read_lo_q <= '0;
      read_hi_q <= '1;
      seq_hi_q  <= '1;
      ref_hi_q  <= '1;
    end else if (en_i) begin
      if (item_i.func == FUNC_START) begin
        reverse_q <= item_i.is_reverse;
        if (item_i.is_reverse) begin
          read_lo_q <= total;
          read_hi_q <= total - PB'(1);
        end else begin
          read_lo_q <= '0;
          read_hi_q <= '1;
        end
        seq_hi_q <= '1;
        ref_hi_q <= PB'(item_i.start_position) - PB'(1);
      end else if (req_i.valid) begin
        read_lo_q <= read_lo_d;
        read_hi_q <= read_hi_d;
        seq_hi_q  <= seq_hi_d;
        ref_hi_q  <= ref_hi_d;
      end
    end
  end

endmodule

`default_nettype wire

[hdl/cigar_cs_alignment_walker.sv]
// Top level of the CIGAR and cs-tag alignment walker.
//
//   channel   direction   payload      transaction
//   in_i      sink        cawk_in_t    start, CIGAR word, cs byte or end of tag
//   out_o     source      cawk_out_t   one finished operation with its intervals
//
// One item is taken per clock cycle while the output is not stalled. An item
// is held in the input register and its result, if any, moves on to the output register.
// The input register takes an item while a result waits only if it is empty, so one
// stalled result holds at most one more item. Reset needs no clearing pass.
`default_nettype none

module cigar_cs_alignment_walker (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  cawk_in_if.sink     in_i,
  cawk_out_if.source  out_o
);
  import cawk_pkg::*;

  logic      in_valid_q;
  cawk_in_t  in_data_q;
  logic      out_valid_q;
  cawk_out_t out_data_q;
  logic      advance;
  cawk_req_t req;
  cawk_out_t result;

  assign advance     = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready  = !in_valid_q || advance;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  cawk_decode u_decode (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (advance),
    .item_i (in_data_q),
    .req_o  (req)
  );

  cawk_track u_track (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (advance),
    .item_i   (in_data_q),
    .req_i    (req),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.valid && in_i.ready) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= req.valid;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_data_q <= in_i.data;
    end
    if (advance) begin
      out_data_q <= result;
    end
  end

endmodule

`default_nettype wire

[hdl/cawk_checker.sv]
// Port-level checks of the alignment walker, bound to its top level.
`default_nettype none

module cawk_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_ready_i,
  input wire logic                out_valid_i,
  input wire logic                out_ready_i,
  input wire cawk_pkg::cawk_out_t out_data_i
);
  import cawk_pkg::*;

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_data_i))
    else $error("stalled result changed");

  // A result that appears on an empty output came from an input transaction.
  a_out_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i, 2))
    else $error("result without a matching input transaction");

  // A deletion does not move the sequence interval.
  a_del_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_data_i.op_code == OP_D) |->
      (out_data_i.seq_end[30:0] == out_data_i.seq_start - 31'd1))
    else $error("deletion stepped the sequence");

endmodule

bind cigar_cs_alignment_walker cawk_checker u_cawk_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);

`default_nettype wire
